[rtl/osgp_pkg.sv]
// Shared types, constants and elaboration-time tables for the object speaker gain panner.
package osgp_pkg;

    // Output format: unsigned Q2.COEF_FRAC_BITS in 16 bits.
    localparam int COEF_FRAC_BITS = 14;
    localparam int Q30_FRAC = 30;
    localparam int OUT_SHIFT = Q30_FRAC - COEF_FRAC_BITS;
    localparam int OUT_W = 16;
    localparam int OUT_MAX = 65535;

    localparam int SPK_N = 9;
    localparam int SINE_N = 21;
    localparam int LEVEL_N = 64;
    localparam int Q_W = 32;
    localparam int SUM_W = 34;
    localparam int ACC_W = 35;

    localparam int SPK_L = 0;
    localparam int SPK_R = 1;
    localparam int SPK_C = 2;
    localparam int SPK_LS = 3;
    localparam int SPK_RS = 4;
    localparam int SPK_TFL = 5;
    localparam int SPK_TFR = 6;
    localparam int SPK_TBL = 7;
    localparam int SPK_TBR = 8;

    localparam logic signed [4:0] POS_LO = -5'sd10;
    localparam logic signed [4:0] POS_HI = 5'sd10;
    localparam logic [3:0] HEIGHT_HI = 4'd10;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] NANO = 64'd1000000000;
    localparam logic [31:0] HALF_DB_UP_NANO = 32'd1059253725;
    localparam logic [31:0] HALF_DB_DOWN_NANO = 32'd944060876;
    localparam int UNITY_CODE = 12;
    localparam int SILENT_CODE = 63;

    localparam logic [ACC_W-1:0] OUT_HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (OUT_SHIFT - 1);

    typedef logic [Q_W-1:0] q30_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [0:SINE_N-1][Q_W-1:0] sine_tab_t;
    typedef logic [0:LEVEL_N-1][Q_W-1:0] level_tab_t;
    typedef logic [SPK_N-1:0][OUT_W-1:0] gain_vec_t;

    typedef enum logic [1:0] {
        LAYOUT_514 = 2'd0,
        LAYOUT_51  = 2'd1,
        LAYOUT_20  = 2'd2
    } layout_t;

    // Pan factors and level of one object, all Q30.
    typedef struct packed {
        q30_t x_up;
        q30_t x_dn;
        q30_t y_up;
        q30_t y_dn;
        q30_t z_up;
        q30_t z_dn;
        q30_t c_left;
        q30_t c_center;
        q30_t c_right;
        q30_t level;
    } pan_fac_t;

    // Full products for the nine speakers plus the two stereo front terms.
    typedef struct packed {
        q30_t [SPK_N-1:0] spk;
        q30_t stereo_l;
        q30_t stereo_r;
    } mix_t;

    // sin(m*pi/40), m = 0..20, in units of 1e-9.
    localparam sine_tab_t SINE_NANO = {
        32'd0,         32'd78459096,  32'd156434465, 32'd233445364, 32'd309016994,
        32'd382683432, 32'd453990500, 32'd522498565, 32'd587785252, 32'd649448048,
        32'd707106781, 32'd760405966, 32'd809016994, 32'd852640164, 32'd891006524,
        32'd923879533, 32'd951056516, 32'd972369920, 32'd987688341, 32'd996917334,
        32'd1000000000
    };

    function automatic logic [63:0] nano_to_q30(input logic [31:0] n);
        logic [63:0] t;
        t = ({32'd0, n} << Q30_FRAC) + (NANO / 2);
        return t / NANO;
    endfunction

    function automatic logic [63:0] qmul64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b + (64'd1 << (Q30_FRAC - 1));
        return p >> Q30_FRAC;
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        logic [63:0] v;
        for (int i = 0; i < SINE_N; i++) begin
            v = nano_to_q30(SINE_NANO[i]);
            tab[i] = v[Q_W-1:0];
        end
        return tab;
    endfunction

    // Level per gain code: unity at code 12, half-dB steps, silence at code 63.
    function automatic level_tab_t build_level_tab();
        level_tab_t tab;
        logic [63:0] g;
        logic [63:0] up;
        logic [63:0] dn;
        up = nano_to_q30(HALF_DB_UP_NANO);
        dn = nano_to_q30(HALF_DB_DOWN_NANO);
        for (int c = 0; c < LEVEL_N; c++) begin
            g = Q30_ONE;
            if (c >= SILENT_CODE) begin
                g = 64'd0;
            end else if (c <= UNITY_CODE) begin
                for (int i = c; i < UNITY_CODE; i++) g = qmul64(g, up);
            end else begin
                for (int i = UNITY_CODE; i < c; i++) g = qmul64(g, dn);
            end
            tab[c] = g[Q_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_Q30 = build_sine_tab();
    localparam level_tab_t LEVEL_Q30 = build_level_tab();
    // The -3 dB fold factor is sin(pi/4).
    localparam q30_t FOLD_Q30 = SINE_Q30[10];

    // Q30 by Q30 product rounded half up; callers keep results below 2^32.
    function automatic q30_t q30_mul(input q30_t a, input q30_t b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        p = p + (64'd1 << (Q30_FRAC - 1));
        return p[Q30_FRAC+Q_W-1:Q30_FRAC];
    endfunction

endpackage

[rtl/osgp_pan_lookup.sv]
// Position clamping and sine/level table lookup, one register stage.
module osgp_pan_lookup (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [4:0]        x_pos,
    input  logic signed [4:0]        y_pos,
    input  logic [3:0]               z_pos,
    input  logic [5:0]               gain_code,
    output logic                     out_valid,
    input  logic                     out_ready,
    output osgp_pkg::pan_fac_t       fac
);
    import osgp_pkg::*;

    logic             v_reg;
    logic             stg_rdy;
    pan_fac_t         fac_reg;
    pan_fac_t         fac_next;
    logic signed [4:0] x_cl;
    logic signed [4:0] y_cl;
    logic [3:0]       z_cl;
    logic signed [5:0] xs;
    logic signed [5:0] ys;
    logic signed [5:0] x2;
    logic signed [5:0] t_cl;
    logic signed [5:0] t_cc;
    logic [4:0]       z2;

    assign stg_rdy = !v_reg || out_ready;
    assign in_ready = stg_rdy;
    assign out_valid = v_reg;
    assign fac = fac_reg;

    always_comb begin
        x_cl = x_pos;
        if (x_pos < POS_LO) x_cl = POS_LO;
        if (x_pos > POS_HI) x_cl = POS_HI;
        y_cl = y_pos;
        if (y_pos < POS_LO) y_cl = POS_LO;
        if (y_pos > POS_HI) y_cl = POS_HI;
        z_cl = (z_pos > HEIGHT_HI) ? HEIGHT_HI : z_pos;

        xs = {x_cl[4], x_cl};
        ys = {y_cl[4], y_cl};
        x2 = xs <<< 1;
        z2 = {z_cl, 1'b0};
        // Three-way front split: left and center share the left half, right and
        // center the right half.
        t_cl = 6'sd0 - x2;
        t_cc = x_cl[4] ? ((xs + 6'sd10) <<< 1) : (6'sd20 - x2);

        fac_next.x_up = SINE_Q30[5'(xs + 6'sd10)];
        fac_next.x_dn = SINE_Q30[5'(6'sd10 - xs)];
        fac_next.y_up = SINE_Q30[5'(ys + 6'sd10)];
        fac_next.y_dn = SINE_Q30[5'(6'sd10 - ys)];
        fac_next.z_up = SINE_Q30[z2];
        fac_next.z_dn = SINE_Q30[5'd20 - z2];
        fac_next.c_left = x_cl[4] ? SINE_Q30[t_cl[4:0]] : '0;
        fac_next.c_right = x_cl[4] ? '0 : SINE_Q30[x2[4:0]];
        fac_next.c_center = SINE_Q30[t_cc[4:0]];
        fac_next.level = LEVEL_Q30[gain_code];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (stg_rdy) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy && in_valid) begin
            fac_reg <= fac_next;
        end
    end

endmodule

[rtl/osgp_gain_matrix.sv]
// Three multiplier stages forming the left-right, back-front, height and level products.
module osgp_gain_matrix (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  osgp_pkg::pan_fac_t fac,
    output logic               out_valid,
    input  logic               out_ready,
    output osgp_pkg::mix_t     mix
);
    import osgp_pkg::*;

    localparam int XY_N = 7;
    localparam int XY_CL_YU = 0;
    localparam int XY_CR_YU = 1;
    localparam int XY_CC_YU = 2;
    localparam int XY_XD_YD = 3;
    localparam int XY_XU_YD = 4;
    localparam int XY_XD_YU = 5;
    localparam int XY_XU_YU = 6;

    logic [2:0]          v_reg;
    logic [2:0]          stg_rdy;

    q30_t [XY_N-1:0]     xy_reg;
    q30_t [XY_N-1:0]     xy_next;
    q30_t                zu1_reg;
    q30_t                zd1_reg;
    q30_t                lvl1_reg;
    q30_t                lvl2_reg;
    mix_t                xyz_reg;
    mix_t                xyz_next;
    mix_t                mix_reg;
    mix_t                mix_next;

    assign stg_rdy[2] = !v_reg[2] || out_ready;
    assign stg_rdy[1] = !v_reg[1] || stg_rdy[2];
    assign stg_rdy[0] = !v_reg[0] || stg_rdy[1];
    assign in_ready = stg_rdy[0];
    assign out_valid = v_reg[2];
    assign mix = mix_reg;

    always_comb begin
        xy_next[XY_CL_YU] = q30_mul(fac.c_left, fac.y_up);
        xy_next[XY_CR_YU] = q30_mul(fac.c_right, fac.y_up);
        xy_next[XY_CC_YU] = q30_mul(fac.c_center, fac.y_up);
        xy_next[XY_XD_YD] = q30_mul(fac.x_dn, fac.y_dn);
        xy_next[XY_XU_YD] = q30_mul(fac.x_up, fac.y_dn);
        xy_next[XY_XD_YU] = q30_mul(fac.x_dn, fac.y_up);
        xy_next[XY_XU_YU] = q30_mul(fac.x_up, fac.y_up);
    end

    always_comb begin
        xyz_next.spk[SPK_L]   = q30_mul(xy_reg[XY_CL_YU], zd1_reg);
        xyz_next.spk[SPK_R]   = q30_mul(xy_reg[XY_CR_YU], zd1_reg);
        xyz_next.spk[SPK_C]   = q30_mul(xy_reg[XY_CC_YU], zd1_reg);
        xyz_next.spk[SPK_LS]  = q30_mul(xy_reg[XY_XD_YD], zd1_reg);
        xyz_next.spk[SPK_RS]  = q30_mul(xy_reg[XY_XU_YD], zd1_reg);
        xyz_next.spk[SPK_TFL] = q30_mul(xy_reg[XY_XD_YU], zu1_reg);
        xyz_next.spk[SPK_TFR] = q30_mul(xy_reg[XY_XU_YU], zu1_reg);
        xyz_next.spk[SPK_TBL] = q30_mul(xy_reg[XY_XD_YD], zu1_reg);
        xyz_next.spk[SPK_TBR] = q30_mul(xy_reg[XY_XU_YD], zu1_reg);
        // Stereo front pair: plain two-way left-right split without center.
        xyz_next.stereo_l     = q30_mul(xy_reg[XY_XD_YU], zd1_reg);
        xyz_next.stereo_r     = q30_mul(xy_reg[XY_XU_YU], zd1_reg);
    end

    always_comb begin
        for (int k = 0; k < SPK_N; k++) begin
            mix_next.spk[k] = q30_mul(xyz_reg.spk[k], lvl2_reg);
        end
        mix_next.stereo_l = q30_mul(xyz_reg.stereo_l, lvl2_reg);
        mix_next.stereo_r = q30_mul(xyz_reg.stereo_r, lvl2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (stg_rdy[0]) v_reg[0] <= in_valid;
            if (stg_rdy[1]) v_reg[1] <= v_reg[0];
            if (stg_rdy[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[0] && in_valid) begin
            xy_reg <= xy_next;
            zu1_reg <= fac.z_up;
            zd1_reg <= fac.z_dn;
            lvl1_reg <= fac.level;
        end
        if (stg_rdy[1] && v_reg[0]) begin
            xyz_reg <= xyz_next;
            lvl2_reg <= lvl1_reg;
        end
        if (stg_rdy[2] && v_reg[1]) begin
            mix_reg <= mix_next;
        end
    end

endmodule

[rtl/osgp_layout_fold.sv]
// Layout folding, output rounding and saturation over four register stages.
module osgp_layout_fold (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  osgp_pkg::mix_t        mix,
    input  osgp_pkg::layout_t     layout,
    output logic                  out_valid,
    input  logic                  out_ready,
    output osgp_pkg::gain_vec_t   gains
);
    import osgp_pkg::*;

    localparam int HGT_N = 4;

    logic [3:0]          v_reg;
    logic [3:0]          stg_rdy;

    mix_t                mix1_reg;
    q30_t [HGT_N-1:0]    p_reg;
    q30_t [HGT_N-1:0]    p_next;
    sum_t [SPK_N-1:0]    val2_reg;
    sum_t [SPK_N-1:0]    val2_next;
    q30_t [1:0]          a_reg;
    q30_t [1:0]          a_next;
    sum_t [SPK_N-1:0]    val3_reg;
    q30_t [1:0]          q_reg;
    q30_t [1:0]          q_next;
    gain_vec_t           gains_reg;
    gain_vec_t           gains_next;
    logic                stereo;
    sum_t [SPK_N-1:0]    raw;
    sum_t                fold_l;
    sum_t                fold_r;
    sum_t                fold_ls;
    sum_t                fold_rs;
    logic [ACC_W-1:0]    acc [SPK_N];
    logic [ACC_W-1:0]    shr [SPK_N];

    assign stg_rdy[3] = !v_reg[3] || out_ready;
    assign stg_rdy[2] = !v_reg[2] || stg_rdy[3];
    assign stg_rdy[1] = !v_reg[1] || stg_rdy[2];
    assign stg_rdy[0] = !v_reg[0] || stg_rdy[1];
    assign in_ready = stg_rdy[0];
    assign out_valid = v_reg[3];
    assign gains = gains_reg;
    assign stereo = (layout != LAYOUT_514) && (layout != LAYOUT_51);

    // Heights scaled by -3 dB, in top front left .. top back right order.
    always_comb begin
        for (int k = 0; k < HGT_N; k++) begin
            p_next[k] = q30_mul(FOLD_Q30, mix.spk[SPK_TFL + k]);
        end
    end

    always_comb begin
        for (int k = 0; k < SPK_N; k++) begin
            raw[k] = SUM_W'(mix1_reg.spk[k]);
        end
        fold_l  = raw[SPK_L] + SUM_W'(p_reg[0]);
        fold_r  = raw[SPK_R] + SUM_W'(p_reg[1]);
        fold_ls = raw[SPK_LS] + SUM_W'(p_reg[2]);
        fold_rs = raw[SPK_RS] + SUM_W'(p_reg[3]);
        // Folded surrounds stay below 2^32 for every level the table holds.
        a_next[0] = fold_ls[Q_W-1:0];
        a_next[1] = fold_rs[Q_W-1:0];
        val2_next = '0;
        unique case (layout)
            LAYOUT_514: begin
                val2_next = raw;
            end
            LAYOUT_51: begin
                val2_next[SPK_L]  = fold_l;
                val2_next[SPK_R]  = fold_r;
                val2_next[SPK_C]  = raw[SPK_C];
                val2_next[SPK_LS] = fold_ls;
                val2_next[SPK_RS] = fold_rs;
            end
            default: begin
                // Stereo: the folded surrounds join the front pair in the last stage.
                val2_next[SPK_L] = SUM_W'(mix1_reg.stereo_l) + SUM_W'(p_reg[0]);
                val2_next[SPK_R] = SUM_W'(mix1_reg.stereo_r) + SUM_W'(p_reg[1]);
            end
        endcase
    end

    always_comb begin
        q_next[0] = q30_mul(FOLD_Q30, a_reg[0]);
        q_next[1] = q30_mul(FOLD_Q30, a_reg[1]);
    end

    always_comb begin
        for (int k = 0; k < SPK_N; k++) begin
            acc[k] = ACC_W'(val3_reg[k]) + OUT_HALF;
            if (stereo && (k == SPK_L)) acc[k] = acc[k] + ACC_W'(q_reg[0]);
            if (stereo && (k == SPK_R)) acc[k] = acc[k] + ACC_W'(q_reg[1]);
            shr[k] = acc[k] >> OUT_SHIFT;
            if (shr[k] > ACC_W'(OUT_MAX)) begin
                gains_next[k] = OUT_W'(OUT_MAX);
            end else begin
                gains_next[k] = shr[k][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (stg_rdy[0]) v_reg[0] <= in_valid;
            if (stg_rdy[1]) v_reg[1] <= v_reg[0];
            if (stg_rdy[2]) v_reg[2] <= v_reg[1];
            if (stg_rdy[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[0] && in_valid) begin
            mix1_reg <= mix;
            p_reg <= p_next;
        end
        if (stg_rdy[1] && v_reg[0]) begin
            val2_reg <= val2_next;
            a_reg <= a_next;
        end
        if (stg_rdy[2] && v_reg[1]) begin
            val3_reg <= val2_reg;
            q_reg <= q_next;
        end
        if (stg_rdy[3] && v_reg[2]) begin
            gains_reg <= gains_next;
        end
    end

endmodule

[rtl/object_speaker_gain_panner.sv]
// Top level of the object speaker gain panner: stream ports, layout register and pipeline.
// Pipeline: an accepted input transaction passes 1 lookup stage, 3 multiplier stages
// and 4 fold and rounding stages on its way to m_tvalid.
// Throughput: one object per cycle while m_tready does not stall it; every stage holds
// its own valid bit, so bubbles are squeezed out and the last stage is the output register.
// Reset: synchronous active-low aresetn empties the pipeline and sets the layout to 5.1.4.
module object_speaker_gain_panner (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0 up: x_pos[4:0], y_pos[9:5], z_pos[13:10], gain_code[19:14],
    // zero padding [23:20].
    input  logic [23:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0 up, 16 bits each: gain_left, gain_right, gain_center,
    // gain_left_surround, gain_right_surround, gain_top_front_left,
    // gain_top_front_right, gain_top_back_left, gain_top_back_right.
    output logic [143:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data
);
    import osgp_pkg::*;

    // The layout register selects 5.1.4, 5.1 with folded heights, or the stereo fold.
    // It is meant to be written only while no transaction is in flight, so it is
    // read directly by the fold stages.
    layout_t   layout_reg;
    logic      lk_valid;
    logic      lk_ready;
    pan_fac_t  fac;
    logic      mx_valid;
    logic      mx_ready;
    mix_t      mix;
    gain_vec_t gains;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg <= LAYOUT_514;
        end else if (cfg_valid && cfg_ready) begin
            layout_reg <= layout_t'(cfg_data);
        end
    end

    // Stage 1: clamp the position and look up the sine pan factors and the level.
    osgp_pan_lookup u_lookup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_pos     (s_tdata[4:0]),
        .y_pos     (s_tdata[9:5]),
        .z_pos     (s_tdata[13:10]),
        .gain_code (s_tdata[19:14]),
        .out_valid (lk_valid),
        .out_ready (lk_ready),
        .fac       (fac)
    );

    // Stages 2 to 4: left-right times back-front, then height, then level.
    osgp_gain_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lk_valid),
        .in_ready  (lk_ready),
        .fac       (fac),
        .out_valid (mx_valid),
        .out_ready (mx_ready),
        .mix       (mix)
    );

    // Stages 5 to 8: height and surround folds, rounding to the output format and
    // saturation.
    osgp_layout_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mx_valid),
        .in_ready  (mx_ready),
        .mix       (mix),
        .layout    (layout_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .gains     (gains)
    );

    assign m_tdata = gains;

    // The input is only ever held off when every stage is full and the output is stalled.
    a_backpressure_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the pipeline could advance");

    // A reset cycle leaves no result pending.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A full pipeline with a stalled output takes nothing in and holds its result.
    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && !s_tready) |=> $stable(m_tdata))
        else $error("held result changed while the pipeline was full");

endmodule

[test/tb_object_speaker_gain_panner.sv]
// Self-checking testbench for the object speaker gain panner: directed and random objects.
module tb_object_speaker_gain_panner;
    timeunit 1ns;
    timeprecision 1ps;

    import osgp_pkg::*;

    // The pipeline is eight stages deep. A generous margin covers the wait for
    // stray results at the end of the run.
    localparam int TAIL_CYCLES = 40;
    // The limit is far above the slowest correct run, even with every result
    // waiting out long receiver stalls and every object behind a long sender gap.
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 475;
    localparam int MAX_PRINTED_ERRORS = 40;
    // Layout code 3 has no name in the package; the block folds it to stereo.
    localparam logic [1:0] LAYOUT_SPARE = 2'd3;
    localparam int GAIN_SHIFT = Q30_FRAC - COEF_FRAC_BITS;
    localparam logic [63:0] NANO_UNIT = 64'd1000000000;
    localparam logic [63:0] HALF_DB_GAIN_UP = 64'd1059253725;
    localparam logic [63:0] HALF_DB_GAIN_DOWN = 64'd944060876;
    localparam int GAIN_CODE_UNITY = 12;
    localparam int GAIN_CODE_MUTE = 63;

    // One object as it travels in s_tdata; the first field sits in the lowest bits.
    typedef struct packed {
        logic [3:0]        pad;
        logic [5:0]        gain_code;
        logic [3:0]        z_pos;
        logic signed [4:0] y_pos;
        logic signed [4:0] x_pos;
    } object_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_data = '0;

    // Gains the predictor worked out for every accepted object, oldest first.
    gain_vec_t   expected_gains_q[$];
    // Our copy of the layout register, updated when the write transaction completes.
    logic [1:0]  layout_now = LAYOUT_514;
    int          error_count = 0;
    int          cycle_count = 0;
    int          src_gap_pct = 0;
    int          sink_stall_pct = 0;

    // Pan law and level tables, filled once at time zero.
    logic [63:0] sine_by_step[21];
    logic [63:0] level_by_code[64];

    const string SPEAKER_NAME[SPK_N] = '{"left", "right", "center", "left_surround",
        "right_surround", "top_front_left", "top_front_right", "top_back_left",
        "top_back_right"};

    object_speaker_gain_panner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor. Every pan factor and the level are Q30 values; products are
    // rounded half up back to Q30, and a speaker gain is rounded to the
    // output format and saturated at the very end.
    // ------------------------------------------------------------------

    function automatic logic [63:0] q30_from_nano(input logic [63:0] n);
        return ((n << Q30_FRAC) + NANO_UNIT / 2) / NANO_UNIT;
    endfunction

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << (Q30_FRAC - 1))) >> Q30_FRAC;
    endfunction

    function automatic logic [63:0] sine_at(input int m);
        if (m < 0) m = 0;
        if (m > 20) m = 20;
        return sine_by_step[m];
    endfunction

    function automatic int clamp_pos(input logic signed [4:0] p);
        int v;
        v = p;
        if (v < -10) v = -10;
        if (v > 10) v = 10;
        return v;
    endfunction

    // Product of three pan factors and the level, rounded after each multiply.
    function automatic logic [63:0] pan_product(input logic [63:0] a, input logic [63:0] b,
                                                input logic [63:0] c, input logic [63:0] lvl);
        return mul_q30(mul_q30(mul_q30(a, b), c), lvl);
    endfunction

    function automatic logic [15:0] round_to_gain(input logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << (GAIN_SHIFT - 1))) >> GAIN_SHIFT;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic gain_vec_t predict_gains(input object_t obj, input logic [1:0] layout);
        int x, y, z;
        logic [63:0] lvl, xu, xd, yu, yd, zu, zd, cl, cc, cr, fold;
        logic [63:0] mix[SPK_N];
        gain_vec_t gains;
        x = clamp_pos(obj.x_pos);
        y = clamp_pos(obj.y_pos);
        z = (obj.z_pos > 4'd10) ? 10 : int'(obj.z_pos);
        lvl = level_by_code[obj.gain_code];
        xu = sine_at(x + 10);
        xd = sine_at(10 - x);
        yu = sine_at(y + 10);
        yd = sine_at(10 - y);
        zu = sine_at(2 * z);
        zd = sine_at(20 - 2 * z);
        // Front row: left of center splits L/C, right of center splits C/R.
        cl = (x < 0) ? sine_at(-2 * x) : 64'd0;
        cr = (x < 0) ? 64'd0 : sine_at(2 * x);
        cc = (x < 0) ? sine_at(2 * (x + 10)) : sine_at(20 - 2 * x);
        fold = sine_at(10);

        mix[SPK_L]   = pan_product(cl, yu, zd, lvl);
        mix[SPK_R]   = pan_product(cr, yu, zd, lvl);
        mix[SPK_C]   = pan_product(cc, yu, zd, lvl);
        mix[SPK_LS]  = pan_product(xd, yd, zd, lvl);
        mix[SPK_RS]  = pan_product(xu, yd, zd, lvl);
        mix[SPK_TFL] = pan_product(xd, yu, zu, lvl);
        mix[SPK_TFR] = pan_product(xu, yu, zu, lvl);
        mix[SPK_TBL] = pan_product(xd, yd, zu, lvl);
        mix[SPK_TBR] = pan_product(xu, yd, zu, lvl);

        if (layout != LAYOUT_514) begin
            // Heights fold at -3 dB into the bed speakers below them.
            mix[SPK_L]  += mul_q30(fold, mix[SPK_TFL]);
            mix[SPK_R]  += mul_q30(fold, mix[SPK_TFR]);
            mix[SPK_LS] += mul_q30(fold, mix[SPK_TBL]);
            mix[SPK_RS] += mul_q30(fold, mix[SPK_TBR]);
            if (layout != LAYOUT_51) begin
                // Stereo: plain two-way L/R with the already folded surrounds added.
                mix[SPK_L] = pan_product(xd, yu, zd, lvl) + mul_q30(fold, mix[SPK_TFL])
                             + mul_q30(fold, mix[SPK_LS]);
                mix[SPK_R] = pan_product(xu, yu, zd, lvl) + mul_q30(fold, mix[SPK_TFR])
                             + mul_q30(fold, mix[SPK_RS]);
                mix[SPK_C]  = 64'd0;
                mix[SPK_LS] = 64'd0;
                mix[SPK_RS] = 64'd0;
            end
            mix[SPK_TFL] = 64'd0;
            mix[SPK_TFR] = 64'd0;
            mix[SPK_TBL] = 64'd0;
            mix[SPK_TBR] = 64'd0;
        end

        for (int k = 0; k < SPK_N; k++) gains[k] = round_to_gain(mix[k]);
        return gains;
    endfunction

    function automatic void build_gain_tables();
        logic [63:0] sine_nano[21];
        logic [63:0] g, up, dn;
        sine_nano = '{64'd0, 64'd78459096, 64'd156434465, 64'd233445364, 64'd309016994,
                      64'd382683432, 64'd453990500, 64'd522498565, 64'd587785252,
                      64'd649448048, 64'd707106781, 64'd760405966, 64'd809016994,
                      64'd852640164, 64'd891006524, 64'd923879533, 64'd951056516,
                      64'd972369920, 64'd987688341, 64'd996917334, 64'd1000000000};
        for (int m = 0; m < 21; m++) sine_by_step[m] = q30_from_nano(sine_nano[m]);
        up = q30_from_nano(HALF_DB_GAIN_UP);
        dn = q30_from_nano(HALF_DB_GAIN_DOWN);
        // Code 12 is unity; every half-dB step is one rounded multiply away from it.
        for (int c = 0; c < 64; c++) begin
            g = 64'd1 << Q30_FRAC;
            if (c >= GAIN_CODE_MUTE) begin
                g = 64'd0;
            end else if (c <= GAIN_CODE_UNITY) begin
                for (int i = c; i < GAIN_CODE_UNITY; i++) g = mul_q30(g, up);
            end else begin
                for (int i = GAIN_CODE_UNITY; i < c; i++) g = mul_q30(g, dn);
            end
            level_by_code[c] = g;
        end
    endfunction

    // ------------------------------------------------------------------
    // Error reporting, result checking, receiver stalls and the watchdog.
    // ------------------------------------------------------------------

    task automatic flag_error(input string msg);
        if (error_count < MAX_PRINTED_ERRORS) $display("ERROR at %0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    // Every output transaction is compared speaker by speaker with the oldest
    // prediction. Values are sampled as they stood just before the edge.
    always @(posedge aclk) begin
        gain_vec_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_gains_q.size() == 0) begin
                flag_error($sformatf("result 0x%h arrived with no object pending", m_tdata));
            end else begin
                want = expected_gains_q.pop_front();
                for (int k = 0; k < SPK_N; k++) begin
                    if (got[k] !== want[k]) begin
                        flag_error($sformatf("gain_%s: expected %0d, got %0d",
                                             SPEAKER_NAME[k], want[k], got[k]));
                    end
                end
            end
        end
    end

    // The receiver drops m_tready on a share of cycles set by the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: run exceeded %0d cycles, %0d results outstanding",
                     CYCLE_LIMIT, expected_gains_q.size());
            $display("** object_speaker_gain_panner: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Each task returns in the time step of the edge at
    // which its transaction completed, so the caller may drive the next one.
    // ------------------------------------------------------------------

    function automatic object_t make_object(input int x, input int y, input int z, input int g);
        object_t obj;
        obj.pad = '0;
        obj.x_pos = 5'(x);
        obj.y_pos = 5'(y);
        obj.z_pos = 4'(z);
        obj.gain_code = 6'(g);
        return obj;
    endfunction

    // Mostly in-range positions, with one field in ten drawn from its full raw range
    // so that the clamping paths get exercised too.
    function automatic object_t random_object();
        int x, y, z;
        x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 20) - 10;
        y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 20) - 10;
        z = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 10);
        return make_object(x, y, z, $urandom_range(0, 63));
    endfunction

    // Sends one object, after an optional random gap, and records its gains on acceptance.
    task automatic send_object(input object_t obj);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= obj;
        do @(posedge aclk); while (!s_tready);
        expected_gains_q.push_back(predict_gains(obj, layout_now));
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (expected_gains_q.size() != 0) @(posedge aclk);
    endtask

    // The layout is only written with the pipeline empty.
    task automatic write_layout(input logic [1:0] code);
        stop_sending();
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data <= code;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        layout_now = code;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Corners of the room, the center split on each side, the gain extremes,
    // silence, and positions outside the legal range, all in the reset layout.
    task automatic test_reset_layout_corners();
        object_t objs[12];
        objs = '{make_object(-10, 10, 0, GAIN_CODE_UNITY),
                 make_object(10, 10, 0, GAIN_CODE_UNITY),
                 make_object(0, 10, 0, GAIN_CODE_UNITY),
                 make_object(-1, 0, 5, GAIN_CODE_UNITY),
                 make_object(1, 0, 5, GAIN_CODE_UNITY),
                 make_object(0, -10, 10, 0),
                 make_object(-10, -10, 10, 0),
                 make_object(10, 10, 0, 62),
                 make_object(0, 0, 0, GAIN_CODE_MUTE),
                 make_object(-16, 15, 15, GAIN_CODE_UNITY),
                 make_object(15, -16, 11, 24),
                 make_object(-11, 11, 15, 5)};
        foreach (objs[i]) send_object(objs[i]);
    endtask

    // The same few objects folded by each of the other layout codes, including
    // the spare code that must behave as stereo.
    task automatic test_layout_folds();
        logic [1:0] codes[3];
        codes = '{LAYOUT_51, LAYOUT_20, LAYOUT_SPARE};
        foreach (codes[c]) begin
            write_layout(codes[c]);
            send_object(make_object(-10, 10, 10, 0));
            send_object(make_object(10, -10, 5, GAIN_CODE_UNITY));
            send_object(make_object(0, 0, 10, GAIN_CODE_MUTE));
        end
    endtask

    // Random objects under one layout and one idling mix. Halfway through the
    // sender holds off until the pipeline has fully drained.
    task automatic test_random_objects(input logic [1:0] layout, input int gap_pct,
                                       input int stall_pct);
        write_layout(layout);
        src_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == ITEMS_PER_PHASE / 2) begin
                stop_sending();
                wait_for_results();
            end
            send_object(random_object());
        end
        stop_sending();
        wait_for_results();
    endtask

    initial begin
        build_gain_tables();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_layout_corners();
        test_layout_folds();
        test_random_objects(LAYOUT_20, 0, 0);
        test_random_objects(LAYOUT_51, 47, 0);
        test_random_objects(LAYOUT_SPARE, 0, 47);
        test_random_objects(LAYOUT_514, 25, 25);

        // Let the pipeline run out so that any stray result is caught.
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_gains_q.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", expected_gains_q.size()));
        end

        if (error_count == 0) begin
            $display("** object_speaker_gain_panner: PASSED **");
        end else begin
            $display("** object_speaker_gain_panner: FAILED **");
        end
        $finish;
    end

endmodule
